// ----- rtl/aksf_pkg.sv -----
// Package for the adaptive scalar Kalman filter: widths, register indexes,
// reset values and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aksf_pkg;

  // Data words are 32-bit fixed point; noise weights are Q1.16 in 17 bits
  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NOISE_W       = 17;
  localparam int NOISE_FRAC    = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [NOISE_W-1:0] Q16_ONE = 17'h1_0000;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

  // Noise floor is the start value divided by this
  localparam logic [7:0] NOISE_FLOOR_DIV = 8'd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_Q0   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R0   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOM  = 2'd3;

  // Reset values
  localparam logic [DATA_W-1:0]  Q0_RESET   = 32'd655;
  localparam logic [DATA_W-1:0]  R0_RESET   = 32'd6554;
  localparam logic [NOISE_W-1:0] RATE_RESET = 17'd6554;
  localparam logic [NOISE_W-1:0] MOM_RESET  = 17'd58982;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_MUL_K,
    ST_WAIT_K,
    ST_UPDATE,
    ST_RESID,
    ST_WAIT_SQ,
    ST_DQ,
    ST_RATE,
    ST_WAIT_RATE,
    ST_TARGET,
    ST_BLEND,
    ST_WAIT_BLEND,
    ST_NOISE,
    ST_FINISH
  } aksf_state_t;

endpackage

`default_nettype wire

// ----- rtl/aksf_if.sv -----
// Valid/ready channel interfaces for samples in and filter results out.
// Depends on aksf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface aksf_sample_if import aksf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic                     first_sample;

  modport source (output valid, output sample, output first_sample, input ready);
  modport sink   (input valid, input sample, input first_sample, output ready);
endinterface

interface aksf_result_if import aksf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate;
  logic        [DATA_W-1:0] covariance;
  logic signed [DATA_W-1:0] innovation;
  logic        [DATA_W-1:0] q_noise;
  logic        [DATA_W-1:0] r_noise;

  modport source (output valid, output estimate, output covariance, output innovation,
                  output q_noise, output r_noise, input ready);
  modport sink   (input valid, input estimate, input covariance, input innovation,
                  input q_noise, input r_noise, output ready);
endinterface

`default_nettype wire

// ----- rtl/aksf_sermul.sv -----
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned multiplier,
// one multiplier bit per cycle. Depends on aksf_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module aksf_sermul import aksf_pkg::*; #(
  parameter int A_W = DATA_W + 1,
  parameter int B_W = DATA_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod,
  output logic               busy
);

  localparam int P_W = A_W + B_W;

  logic [B_W-1:0] mplier;
  logic [P_W-1:0] mcand;
  logic [P_W-1:0] acc;

  // Multiplier shifts out LSB first; done once no set bits remain
  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (start) begin
      mplier <= b;
    end else begin
      mplier <= mplier >> 1;
    end
  end

  // Accumulate the sign-extended multiplicand, doubled each step
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mcand <= {{B_W{a[A_W-1]}}, a};
    end else if (|mplier) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[P_W-2:0], 1'b0};
    end
  end

  assign busy = |mplier;
  assign prod = acc;

endmodule

`default_nettype wire

// ----- rtl/adaptive_scalar_kalman_filter.sv -----
// Adaptive scalar Kalman filter, one sample per request, one result per request.
// The bit-serial gain divider and multipliers set how long a request takes; a first
// sample skips noise adaptation and so finishes sooner.
// Throughput: one request in flight; the next is taken the cycle after the result
// enters the output register. Synchronous reset restores the register and filter defaults.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_scalar_kalman_filter import aksf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  aksf_sample_if.sink          samples,
  aksf_result_if.source        results
);

  localparam int KW     = FRAC_BITS + 1;
  localparam int E2W    = 2 * DATA_W - FRAC_BITS;
  localparam int MA_W   = E2W + 1;
  localparam int MB_W   = DATA_W;
  localparam int MP_W   = MA_W + MB_W;
  localparam int CNT_W  = $clog2(DATA_W + 1);
  localparam int SAT_LO = NOISE_FRAC + DATA_W;
  localparam int BS_W   = DATA_W + NOISE_W + 2;

  localparam logic [KW-1:0]     ONE_K     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DATA_W-1:0] ONE_D     = DATA_W'(ONE_K);
  localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(FRAC_BITS);
  localparam logic [CNT_W-1:0]  D100_STEP = CNT_W'(DATA_W);

  // Configuration registers
  logic [DATA_W-1:0]  q0_cfg, r0_cfg;
  logic [NOISE_W-1:0] rate_cfg, mom_cfg;
  logic [NOISE_W-1:0] rate_c, mom_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      q0_cfg   <= Q0_RESET;
      r0_cfg   <= R0_RESET;
      rate_cfg <= RATE_RESET;
      mom_cfg  <= MOM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_Q0:   q0_cfg   <= cfg_data;
        REG_R0:   r0_cfg   <= cfg_data;
        REG_RATE: rate_cfg <= cfg_data[NOISE_W-1:0];
        REG_MOM:  mom_cfg  <= cfg_data[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // Weights above 1.0 act as 1.0
  assign rate_c = (rate_cfg > Q16_ONE) ? Q16_ONE : rate_cfg;
  assign mom_c  = (mom_cfg > Q16_ONE) ? Q16_ONE : mom_cfg;

  // Filter state and per-request working registers
  aksf_state_t        state, state_next;
  logic [DATA_W-1:0]  prev_est, prev_p, prev_q, prev_r;
  logic [DATA_W-1:0]  z, x_pred, p_pred, q_sel, r_sel, innov;
  logic               first_r;
  logic [DATA_W:0]    s;
  logic [DATA_W+1:0]  div_rem;
  logic [KW-1:0]      k;
  logic [CNT_W-1:0]   cnt;
  logic [DATA_W-1:0]  est, cov;
  logic [E2W-1:0]     e2, adq;
  logic [DATA_W-1:0]  tq, tr, q_new, r_new;
  logic [DATA_W-1:0]  fq_sh, fr_sh;
  logic [6:0]         fq_rem, fr_rem;

  // Output register
  logic               out_valid, out_free;
  logic [DATA_W-1:0]  est_out, cov_out, innov_out, q_out, r_out;

  // Multiplier units
  logic               mul_start, busy_a, busy_b;
  logic [MA_W-1:0]    ma_a, mb_a;
  logic [MB_W-1:0]    ma_b, mb_b;
  logic [MP_W-1:0]    prod_a, prod_b;

  aksf_sermul #(.A_W(MA_W), .B_W(MB_W)) u_mul_a (
    .clk(clk), .rst(rst), .start(mul_start), .a(ma_a), .b(ma_b),
    .prod(prod_a), .busy(busy_a)
  );

  aksf_sermul #(.A_W(MA_W), .B_W(MB_W)) u_mul_b (
    .clk(clk), .rst(rst), .start(mul_start), .a(mb_a), .b(mb_b),
    .prod(prod_b), .busy(busy_b)
  );

  // Prediction from the request and the stored state
  logic [DATA_W:0]   pp_sum, diff_in;
  logic [DATA_W-1:0] pp_sat, xp_acc, pp_acc, q_acc, r_acc, innov_acc;

  always_comb begin
    pp_sum    = {1'b0, prev_p} + {1'b0, prev_q};
    pp_sat    = pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
    xp_acc    = samples.first_sample ? '0 : prev_est;
    pp_acc    = samples.first_sample ? ONE_D : pp_sat;
    q_acc     = samples.first_sample ? q0_cfg : prev_q;
    r_acc     = samples.first_sample ? r0_cfg : prev_r;
    diff_in   = {samples.sample[DATA_W-1], samples.sample} - {xp_acc[DATA_W-1], xp_acc};
    innov_acc = (diff_in[DATA_W] == diff_in[DATA_W-1]) ? diff_in[DATA_W-1:0]
              : (diff_in[DATA_W] ? S32_MIN : S32_MAX);
  end

  // Gain divider step: restoring, one quotient bit a cycle
  logic [DATA_W:0]   s_sum;
  logic [DATA_W+1:0] trial;
  logic              ge;
  logic [KW-1:0]     kc;

  assign s_sum = {1'b0, p_pred} + {1'b0, r_sel};
  assign trial = (cnt == '0) ? div_rem : {div_rem[DATA_W:0], 1'b0};
  assign ge    = trial >= {1'b0, s};
  assign kc    = ONE_K - k;

  // Posterior estimate from the gain product
  logic [DATA_W+1:0] corr, xsum;
  logic [DATA_W-1:0] est_sat;

  assign corr    = prod_a[FRAC_BITS +: DATA_W+2];
  assign xsum    = {{2{x_pred[DATA_W-1]}}, x_pred} + corr;
  assign est_sat = (xsum[DATA_W+1:DATA_W-1] == 3'b000 || xsum[DATA_W+1:DATA_W-1] == 3'b111)
                 ? xsum[DATA_W-1:0] : (xsum[DATA_W+1] ? S32_MIN : S32_MAX);

  // Residual magnitude (always below 2^32)
  logic [DATA_W:0] e_full, mag_full;

  assign e_full   = {z[DATA_W-1], z} - {est[DATA_W-1], est};
  assign mag_full = e_full[DATA_W] ? ('0 - e_full) : e_full;

  // Squared residual and the process-noise mismatch
  logic [E2W-1:0] e2w;
  logic [E2W:0]   dq_full, adq_full;

  assign e2w      = prod_a[FRAC_BITS +: E2W];
  assign dq_full  = {1'b0, e2w} - {{(E2W+1-DATA_W){1'b0}}, prev_p}
                  - {{(E2W+1-DATA_W){1'b0}}, prev_r};
  assign adq_full = dq_full[E2W] ? ('0 - dq_full) : dq_full;

  // Noise targets, saturated after the Q1.16 scale
  logic [DATA_W-1:0] tq_raw, tr_raw;

  assign tq_raw = (|prod_a[MP_W-1:SAT_LO]) ? '1 : prod_a[NOISE_FRAC +: DATA_W];
  assign tr_raw = (|prod_b[MP_W-1:SAT_LO]) ? '1 : prod_b[NOISE_FRAC +: DATA_W];

  // Momentum blend: target*1.0 + (old - target)*m
  logic [DATA_W:0]   bq_diff, br_diff;
  logic [BS_W-1:0]   bsum_q, bsum_r;
  logic [DATA_W-1:0] q_blend, r_blend;

  assign bq_diff = {1'b0, prev_q} - {1'b0, tq};
  assign br_diff = {1'b0, prev_r} - {1'b0, tr};
  assign bsum_q  = {{(BS_W-SAT_LO){1'b0}}, tq, {NOISE_FRAC{1'b0}}} + prod_a[BS_W-1:0];
  assign bsum_r  = {{(BS_W-SAT_LO){1'b0}}, tr, {NOISE_FRAC{1'b0}}} + prod_b[BS_W-1:0];
  assign q_blend = (|bsum_q[BS_W-1:SAT_LO]) ? '1 : bsum_q[NOISE_FRAC +: DATA_W];
  assign r_blend = (|bsum_r[BS_W-1:SAT_LO]) ? '1 : bsum_r[NOISE_FRAC +: DATA_W];

  // Noise floor dividers by a constant, one dividend bit a cycle
  logic [7:0] fq_t, fr_t;
  logic       fq_ge, fr_ge;

  assign fq_t  = {fq_rem, fq_sh[DATA_W-1]};
  assign fr_t  = {fr_rem, fr_sh[DATA_W-1]};
  assign fq_ge = fq_t >= NOISE_FLOOR_DIV;
  assign fr_ge = fr_t >= NOISE_FLOOR_DIV;

  assign out_free = !out_valid || results.ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operands
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    ma_a       = '0;
    ma_b       = '0;
    mb_a       = '0;
    mb_b       = '0;
    unique case (state)
      ST_IDLE:   if (samples.valid) state_next = ST_PRED;
      ST_PRED:   state_next = (s_sum == '0) ? ST_MUL_K : ST_DIV;
      ST_DIV:    if (cnt == DIV_LAST) state_next = ST_MUL_K;
      ST_MUL_K: begin
        mul_start  = 1'b1;
        ma_a       = {{(MA_W-DATA_W){innov[DATA_W-1]}}, innov};
        ma_b       = {{(MB_W-KW){1'b0}}, k};
        mb_a       = {{(MA_W-DATA_W){1'b0}}, p_pred};
        mb_b       = {{(MB_W-KW){1'b0}}, kc};
        state_next = ST_WAIT_K;
      end
      ST_WAIT_K: if (!busy_a && !busy_b) state_next = ST_UPDATE;
      ST_UPDATE: state_next = first_r ? ST_FINISH : ST_RESID;
      ST_RESID: begin
        mul_start  = 1'b1;
        ma_a       = {{(MA_W-DATA_W){1'b0}}, mag_full[DATA_W-1:0]};
        ma_b       = mag_full[DATA_W-1:0];
        state_next = ST_WAIT_SQ;
      end
      ST_WAIT_SQ: if (cnt == D100_STEP && !busy_a) state_next = ST_DQ;
      ST_DQ:     state_next = ST_RATE;
      ST_RATE: begin
        mul_start  = 1'b1;
        ma_a       = {1'b0, adq};
        ma_b       = {{(MB_W-NOISE_W){1'b0}}, rate_c};
        mb_a       = {1'b0, e2};
        mb_b       = {{(MB_W-NOISE_W){1'b0}}, rate_c};
        state_next = ST_WAIT_RATE;
      end
      ST_WAIT_RATE: if (!busy_a && !busy_b) state_next = ST_TARGET;
      ST_TARGET: state_next = ST_BLEND;
      ST_BLEND: begin
        mul_start  = 1'b1;
        ma_a       = {{(MA_W-DATA_W-1){bq_diff[DATA_W]}}, bq_diff};
        ma_b       = {{(MB_W-NOISE_W){1'b0}}, mom_c};
        mb_a       = {{(MA_W-DATA_W-1){br_diff[DATA_W]}}, br_diff};
        mb_b       = {{(MB_W-NOISE_W){1'b0}}, mom_c};
        state_next = ST_WAIT_BLEND;
      end
      ST_WAIT_BLEND: if (!busy_a && !busy_b) state_next = ST_NOISE;
      ST_NOISE:  state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Step counter for the gain divider and the noise floor dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_PRED || state == ST_RESID) begin
      cnt <= '0;
    end else if (state == ST_DIV || (state == ST_WAIT_SQ && cnt != D100_STEP)) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          z       <= samples.sample;
          first_r <= samples.first_sample;
          x_pred  <= xp_acc;
          p_pred  <= pp_acc;
          q_sel   <= q_acc;
          r_sel   <= r_acc;
          innov   <= innov_acc;
        end
      end
      ST_PRED: begin
        s       <= s_sum;
        div_rem <= {1'b0, 1'b0, p_pred};
        k       <= '0;
      end
      ST_DIV: begin
        div_rem <= ge ? (trial - {1'b0, s}) : trial;
        k       <= {k[KW-2:0], ge};
      end
      ST_UPDATE: begin
        est   <= est_sat;
        cov   <= prod_b[FRAC_BITS +: DATA_W];
        q_new <= q_sel;
        r_new <= r_sel;
      end
      ST_RESID: begin
        fq_sh  <= q0_cfg;
        fr_sh  <= r0_cfg;
        fq_rem <= '0;
        fr_rem <= '0;
      end
      ST_WAIT_SQ: begin
        if (cnt != D100_STEP) begin
          fq_rem <= fq_ge ? 7'(fq_t - NOISE_FLOOR_DIV) : fq_t[6:0];
          fr_rem <= fr_ge ? 7'(fr_t - NOISE_FLOOR_DIV) : fr_t[6:0];
          fq_sh  <= {fq_sh[DATA_W-2:0], fq_ge};
          fr_sh  <= {fr_sh[DATA_W-2:0], fr_ge};
        end
      end
      ST_DQ: begin
        e2  <= e2w;
        adq <= adq_full[E2W-1:0];
      end
      ST_TARGET: begin
        tq <= (tq_raw < fq_sh) ? fq_sh : tq_raw;
        tr <= (tr_raw < fr_sh) ? fr_sh : tr_raw;
      end
      ST_NOISE: begin
        q_new <= q_blend;
        r_new <= r_blend;
      end
      default: ;
    endcase
  end

  // Commit the filter state when the result enters the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_est <= '0;
      prev_p   <= ONE_D;
      prev_q   <= Q0_RESET;
      prev_r   <= R0_RESET;
    end else if (state == ST_FINISH && out_free) begin
      prev_est <= est;
      prev_p   <= cov;
      prev_q   <= q_new;
      prev_r   <= r_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      est_out   <= est;
      cov_out   <= cov;
      innov_out <= innov;
      q_out     <= q_new;
      r_out     <= r_new;
    end
  end

  assign samples.ready      = (state == ST_IDLE);
  assign results.valid      = out_valid;
  assign results.estimate   = est_out;
  assign results.covariance = cov_out;
  assign results.innovation = innov_out;
  assign results.q_noise    = q_out;
  assign results.r_noise    = r_out;

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> (state == ST_PRED))
    else $error("accepted request did not start the sequencer");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt != '0) |-> (div_rem < {1'b0, s}))
    else $error("gain divider remainder not below divisor");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESID) |-> (cov <= p_pred))
    else $error("posterior covariance above predicted covariance");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (!busy_a && !busy_b))
    else $error("multiplier still busy when result is committed");

endmodule

`default_nettype wire
